// ===== sv/pkah_pkg.sv =====
`timescale 1ns / 1ps

package pkah_pkg;

  // Port widths fixed by the item format
  localparam int unsigned INDEX_W  = 15;
  localparam int unsigned WEIGHT_W = 32;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 32'sh8000_0000;

  // Saturating Q15.16 accumulate
  function automatic logic signed [WEIGHT_W-1:0] sat_add(
    input logic signed [WEIGHT_W-1:0] a,
    input logic signed [WEIGHT_W-1:0] b
  );
    logic signed [WEIGHT_W:0] s;
    s = {a[WEIGHT_W-1], a} + {b[WEIGHT_W-1], b};
    if (s[WEIGHT_W] != s[WEIGHT_W-1]) begin
      sat_add = s[WEIGHT_W] ? WEIGHT_MIN : WEIGHT_MAX;
    end else begin
      sat_add = s[WEIGHT_W-1:0];
    end
  endfunction

endpackage

// ===== sv/pair_keyed_accumulate_hash_table.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// --------  ---------  -------------------  -------------------------------------------
// command   in         start & !busy        operation, index_first, index_second, delta
// result    out        done (one cycle)     weight, found, dropped, ignored
//
// One item per command; busy stays high while the item is worked.
// Keys are reduced to a slot by reciprocal multiplication when TABLE_SLOTS is
// not a power of two. A same-index add is answered from idle, without a probe,
// as ignored. Each probe costs a RAM read and a compare, so the probe chain
// length of linear probing sets the time taken per item.
// Reset (rst, synchronous, active high) starts a clearing pass over the whole
// slot RAM; busy is high during it. The receiver cannot stall: done is
// high for exactly one cycle per item, and a new item may be taken in that cycle.

module pair_keyed_accumulate_hash_table
  import pkah_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 4096,
  parameter int unsigned INDEX_BITS  = 15
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation,
  input  logic [INDEX_W-1:0]         index_first,
  input  logic [INDEX_W-1:0]         index_second,
  input  logic signed [WEIGHT_W-1:0] delta,
  output logic                       done,
  output logic signed [WEIGHT_W-1:0] weight,
  output logic                       found,
  output logic                       dropped,
  output logic                       ignored
);

  localparam int unsigned KEY_W   = 2 * INDEX_BITS;
  localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int unsigned EXT_W   = (KEY_W > SLOT_W + 1) ? KEY_W : SLOT_W + 1;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned ENTRY_W = KEY_W + WEIGHT_W;
  localparam bit          IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [SLOT_W:0]   MODULUS   = (SLOT_W + 1)'(TABLE_SLOTS);
  // floor(2^KEY_W / TABLE_SLOTS): the quotient estimate is at most one short
  localparam logic [EXT_W-1:0]  RECIP     = EXT_W'((64'd1 << KEY_W) / TABLE_SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_CHECK
  } state_t;

  state_t state;

  // Item registers
  op_t                       op_q;
  logic [KEY_W-1:0]          key_q;
  logic signed [WEIGHT_W-1:0] delta_q;

  // Probe position doubles as the clear-pass address
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] probe_cnt;

  // Remainder by reciprocal multiplication
  logic [EXT_W-1:0]   mod_key;
  logic [CNT_W-1:0]   mod_cnt;
  logic [2*EXT_W-1:0] mod_prod;
  logic [EXT_W-1:0]   mod_quot;
  logic [SLOT_W:0]    mod_qm;
  logic [SLOT_W:0]    rem;
  logic [SLOT_W:0]    rem_next;

  // Incoming pair, ordered and packed
  logic [INDEX_BITS-1:0] idx_a;
  logic [INDEX_BITS-1:0] idx_b;
  logic [KEY_W-1:0]      key_in;
  logic [EXT_W-1:0]      key_ext;

  // Slot RAM
  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic signed [WEIGHT_W-1:0] rd_weight;
  logic signed [WEIGHT_W-1:0] acc_weight;
  logic                slot_empty;
  logic                slot_match;
  logic [SLOT_W-1:0]   slot_inc;

  assign idx_a   = index_first[INDEX_BITS-1:0];
  assign idx_b   = index_second[INDEX_BITS-1:0];
  assign key_in  = (idx_a < idx_b) ? {idx_a, idx_b} : {idx_b, idx_a};
  assign key_ext = EXT_W'(key_in);

  // Low bits only: the true remainder before correction lies below twice the modulus
  assign mod_quot = mod_prod[KEY_W +: EXT_W];
  assign rem      = mod_key[SLOT_W:0] - mod_qm;
  assign rem_next = (rem >= MODULUS) ? (rem - MODULUS) : rem;

  assign rd_key     = ram_rdata[ENTRY_W-1:WEIGHT_W];
  assign rd_weight  = ram_rdata[WEIGHT_W-1:0];
  assign acc_weight = sat_add(rd_weight, delta_q);
  assign slot_empty = (rd_key == '0);
  assign slot_match = (rd_key == key_q);
  assign slot_inc   = (slot == LAST_SLOT) ? '0 : slot + 1'b1;

  assign busy = (state != S_IDLE);

  // Write on clear, on insert into an empty slot, or on accumulate into a match
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_CHECK: begin
        if (op_q == OP_ADD && (slot_empty || slot_match)) begin
          ram_we    = 1'b1;
          ram_wdata = {key_q, slot_empty ? delta_q : acc_weight};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pkah_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      slot      <= '0;
      probe_cnt <= '0;
      mod_cnt   <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          // sweep the key store to empty
          if (slot == LAST_SLOT) begin
            slot  <= '0;
            state <= S_IDLE;
          end else begin
            slot <= slot + 1'b1;
          end
        end

        S_IDLE: begin
          if (start) begin
            op_q      <= op_t'(operation);
            key_q     <= key_in;
            delta_q   <= delta;
            probe_cnt <= '0;
            if (op_t'(operation) == OP_ADD && idx_a == idx_b) begin
              // answer a self-pair add straight away as ignored
              done    <= 1'b1;
              weight  <= '0;
              found   <= 1'b0;
              dropped <= 1'b0;
              ignored <= 1'b1;
            end else if (IS_POW2) begin
              slot  <= key_ext[SLOT_W-1:0];
              state <= S_PROBE;
            end else begin
              mod_key <= key_ext;
              mod_cnt <= '0;
              state   <= S_MOD;
            end
          end
        end

        S_MOD: begin
          // quotient estimate, its product with the modulus, then one correction
          mod_cnt <= mod_cnt + 1'b1;
          if (mod_cnt == '0) begin
            mod_prod <= (2*EXT_W)'(mod_key) * (2*EXT_W)'(RECIP);
          end else if (mod_cnt == CNT_W'(1)) begin
            mod_qm <= mod_quot[SLOT_W:0] * MODULUS;
          end else begin
            slot  <= rem_next[SLOT_W-1:0];
            state <= S_PROBE;
          end
        end

        S_PROBE: begin
          // read issued on slot; data lands next cycle
          state <= S_CHECK;
        end

        S_CHECK: begin
          if (slot_empty || slot_match) begin
            done    <= 1'b1;
            dropped <= 1'b0;
            ignored <= 1'b0;
            found   <= slot_match && !slot_empty;
            state   <= S_IDLE;
            if (op_q == OP_ADD) begin
              weight <= slot_empty ? delta_q : acc_weight;
            end else begin
              weight <= slot_empty ? '0 : rd_weight;
            end
          end else if (probe_cnt == LAST_SLOT) begin
            // whole table walked without a hit or a hole
            done    <= 1'b1;
            weight  <= '0;
            found   <= 1'b0;
            dropped <= (op_q == OP_ADD);
            ignored <= 1'b0;
            state   <= S_IDLE;
          end else begin
            probe_cnt <= probe_cnt + 1'b1;
            slot      <= slot_inc;
            state     <= S_PROBE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/pkah_ram.sv =====
`timescale 1ns / 1ps

module pkah_ram #(
  parameter int unsigned WIDTH = 62,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
